>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, disabled while reset is high
`define SRG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define SRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/srg_pkg.sv
// types, constants and helper functions of the subtractive generator
package srg_pkg;

   localparam int VALUE_W       = 30;
   localparam int DEPTH_DEF     = 55;
   localparam int SCATTER_STEP  = 21;
   localparam int FEEDBACK_TAP  = 31;
   localparam int MIX_PASSES    = 4;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [VALUE_W-1:0] MODULUS    = 30'd1000000000;
   localparam logic [VALUE_W-1:0] SEED_RESET = 30'd161803397;

   // register index on the csr port
   localparam logic REG_SEED = 1'b0;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_SHIFT,
      OP_ROTATE
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_SCATTER,
      ST_MIX,
      ST_DRAW
   } srg_state_type;

   typedef struct packed {
      cell_op_type op;
      logic        emit;
      logic        gen_load;
      logic        gen_step;
   } cell_ctl_type;

   // (a - b) mod 10^9, both operands below the modulus
   function automatic logic [VALUE_W-1:0] sub_mod(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b);
      return (a >= b) ? (a - b) : (a - b + MODULUS);
   endfunction

   // one conditional subtraction is enough at 30 bits
   function automatic logic [VALUE_W-1:0] reduce_seed(input logic [VALUE_W-1:0] s);
      return (s >= MODULUS) ? (s - MODULUS) : s;
   endfunction

endpackage

>>> hw/rtl/srg_channel_if.sv
// valid/ready channel interfaces for draw requests and drawn values
interface srg_req_if;
   logic valid;
   logic ready;
   logic reseed;

   modport source (output valid, output reseed, input ready);
   modport sink   (input valid, input reseed, output ready);
endinterface

interface srg_rsp_if import srg_pkg::*;;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] random_value;

   modport source (output valid, output random_value, input ready);
   modport sink   (input valid, input random_value, output ready);
endinterface

>>> hw/rtl/srg_cell.sv
// one table entry of the lag chain
module srg_cell import srg_pkg::*; (
   input  logic               clock,
   input  cell_op_type        op,
   input  logic [VALUE_W-1:0] shift_in,
   input  logic [VALUE_W-1:0] rot_in,
   output logic [VALUE_W-1:0] value_out
);

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;

   always_comb begin
      case (op)
         OP_SHIFT:  value_in = shift_in;
         OP_ROTATE: value_in = rot_in;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

>>> hw/rtl/srg_seed_gen.sv
// fill sequence: v0 = seed, v1 = 1, v(t+1) = v(t-1) - v(t) mod 10^9
module srg_seed_gen import srg_pkg::*; (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [VALUE_W-1:0] seed,
   output logic [VALUE_W-1:0] value
);

   logic [VALUE_W-1:0] a_ff, a_in;
   logic [VALUE_W-1:0] b_ff, b_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (ctl.gen_load) begin
         a_in = reduce_seed(seed);
         b_in = VALUE_W'(1);
      end else if (ctl.gen_step) begin
         a_in = b_ff;
         b_in = sub_mod(a_ff, b_ff);
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign value = a_ff;

endmodule

>>> hw/rtl/srg_ctrl.sv
// sequencer for table fill, mixing passes and draws
`include "assert_macros.svh"

module srg_ctrl import srg_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_reseed,
   input  logic         out_free,
   output logic         req_ready,
   output cell_ctl_type ctl
);

   localparam int MIX_CYCLES = MIX_PASSES * DEPTH;
   localparam int CNT_W      = $clog2(MIX_CYCLES);

   srg_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             needs_init_ff, needs_init_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         cnt_ff        <= '0;
         needs_init_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         needs_init_ff <= needs_init_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      needs_init_in = needs_init_ff;
      req_ready     = 1'b0;
      ctl           = '{op: OP_HOLD, emit: 1'b0, gen_load: 1'b0, gen_step: 1'b0};
      unique case (state_ff)
         ST_RUN: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               if (needs_init_ff || req_reseed) begin
                  ctl.gen_load = 1'b1;
                  cnt_in       = '0;
                  state_in     = ST_SCATTER;
               end else begin
                  ctl.op   = OP_SHIFT;
                  ctl.emit = 1'b1;
               end
            end
         end
         ST_SCATTER: begin
            ctl.op       = OP_ROTATE;
            ctl.gen_step = 1'b1;
            if (cnt_ff == CNT_W'(DEPTH - 1)) begin
               cnt_in   = '0;
               state_in = ST_MIX;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MIX: begin
            ctl.op = OP_SHIFT;
            if (cnt_ff == CNT_W'(MIX_CYCLES - 1)) begin
               cnt_in        = '0;
               needs_init_in = 1'b0;
               state_in      = ST_DRAW;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAW: begin
            if (out_free) begin
               ctl.op   = OP_SHIFT;
               ctl.emit = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   `SRG_ASSERT(a_mix_count, clock, reset, (state_ff != ST_MIX) || (cnt_ff < CNT_W'(MIX_CYCLES)), "mix counter out of range")
   `SRG_ASSERT(a_init_done, clock, reset, !$fell(needs_init_ff) || (state_ff == ST_DRAW), "init flag cleared outside mix end")
   `SRG_ASSERT_NEXT(a_fill_start, clock, reset, ctl.gen_load, state_ff == ST_SCATTER && cnt_ff == '0, "fill did not start")

endmodule

>>> hw/rtl/subtractive_random_generator_core.sv
// top level of the subtractive lagged random generator (modulus 10^9)
// output: a draw with no fill is registered in the cycle after it is accepted
// throughput: one draw per cycle while the output is taken and no fill runs;
//   the table sits in a chain of 55 cells that shifts by one entry per draw
// fill: the first draw after reset, or a draw with reseed set, first scatters
//   the fill sequence over the chain, then mixes it (4 passes over the chain)
// reset: synchronous, clears control state and loads the seed register default
`include "assert_macros.svh"

module subtractive_random_generator_core import srg_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   srg_req_if.sink               req_chan,
   srg_rsp_if.source             rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // cell where the fill sequence enters while the chain rotates by the
   // scatter step; chosen so the last rotation leaves entry i in cell i-1
   localparam int INSERT_CELL = (SCATTER_STEP * (DEPTH - 1) + DEPTH - 1) % DEPTH;

   // seed register on the csr port
   logic [VALUE_W-1:0] seed_ff, seed_in;
   logic               seed_wr;

   assign csr_pready = 1'b1;
   assign seed_wr    = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_ADDR_W-1] == REG_SEED);

   always_comb begin
      seed_in = seed_ff;
      if (seed_wr) begin
         seed_in = csr_pwdata[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   always_comb begin
      if (csr_paddr[CSR_ADDR_W-1] == REG_SEED) begin
         csr_prdata = CSR_DATA_W'(seed_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   // output beat register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   cell_ctl_type ctl;

   srg_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_reseed (req_chan.reseed),
      .out_free   (out_free),
      .req_ready  (req_chan.ready),
      .ctl        (ctl)
   );

   // fill sequence source
   logic [VALUE_W-1:0] gen_value;

   srg_seed_gen u_seed_gen (
      .clock (clock),
      .ctl   (ctl),
      .seed  (seed_ff),
      .value (gen_value)
   );

   // lag chain: cell k holds the entry k+1 places after the last one drawn.
   // a draw or a mixing step both compute cell 0 minus the feedback tap,
   // shift every entry down by one and feed the difference in at the top
   logic [VALUE_W-1:0] cell_value [DEPTH];
   logic [VALUE_W-1:0] diff;

   assign diff = sub_mod(cell_value[0], cell_value[FEEDBACK_TAP]);

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [VALUE_W-1:0] shift_src;
      logic [VALUE_W-1:0] rot_src;

      if (k == DEPTH - 1) begin : g_top
         assign shift_src = diff;
      end else begin : g_mid
         assign shift_src = cell_value[k + 1];
      end

      // scatter: rotate by the scatter step, fill value enters at one cell
      if (k == INSERT_CELL) begin : g_ins
         assign rot_src = gen_value;
      end else begin : g_rot
         assign rot_src = cell_value[(k + SCATTER_STEP) % DEPTH];
      end

      srg_cell u_cell (
         .clock     (clock),
         .op        (ctl.op),
         .shift_in  (shift_src),
         .rot_in    (rot_src),
         .value_out (cell_value[k])
      );
   end

   // output register: load on a draw, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = diff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.random_value = rsp_value_ff;

   `SRG_ASSERT(a_no_overwrite, clock, reset, !ctl.emit || out_free, "draw would overwrite a waiting beat")
   `SRG_ASSERT(a_value_range, clock, reset, !rsp_valid_ff || (rsp_value_ff < MODULUS), "drawn value not below modulus")
   `SRG_ASSERT_NEXT(a_emit_valid, clock, reset, ctl.emit, rsp_valid_ff, "draw not presented")

endmodule

>>> tb/subtractive_random_generator_core_tb.sv
// testbench of the subtractive random generator: drives draws and seed writes, checks every value
module subtractive_random_generator_core_tb import srg_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // tracks the lag table and holds the values the block still owes
   class draw_scoreboard;
      logic [VALUE_W-1:0] seed_reg;
      int unsigned        lag [1:DEPTH_DEF];
      int unsigned        lead_idx;
      int unsigned        trail_idx;
      bit                 fill_pending;
      logic [VALUE_W-1:0] owed_values [$];
      int unsigned        mismatches;
      int unsigned        checked;

      function new();
         seed_reg     = SEED_RESET;
         lead_idx     = 0;
         trail_idx    = FEEDBACK_TAP;
         fill_pending = 1'b1;
         mismatches   = 0;
         checked      = 0;
         foreach (lag[i]) lag[i] = 0;
      endfunction

      // difference modulo 10^9, both operands already reduced
      function int unsigned wrap_diff(input int unsigned a, input int unsigned b);
         int unsigned modulus;
         modulus = MODULUS;
         return (a >= b) ? (a - b) : (a + modulus - b);
      endfunction

      function int unsigned next_slot(input int unsigned idx);
         return (idx >= DEPTH_DEF) ? 1 : idx + 1;
      endfunction

      // scatter pass from the seed, then the mixing passes
      function void rebuild_table();
         int unsigned carry;
         int unsigned fresh;
         int unsigned slot;
         int unsigned modulus;
         modulus = MODULUS;
         carry   = seed_reg;
         if (carry >= modulus) carry = carry - modulus;
         lag[DEPTH_DEF] = carry;
         fresh = 1;
         for (int unsigned i = 1; i < DEPTH_DEF; i++) begin
            slot      = (SCATTER_STEP * i) % DEPTH_DEF;
            lag[slot] = fresh;
            fresh     = wrap_diff(carry, fresh);
            carry     = lag[slot];
         end
         for (int pass = 0; pass < MIX_PASSES; pass++) begin
            for (int unsigned i = 1; i <= DEPTH_DEF; i++) begin
               lag[i] = wrap_diff(lag[i], lag[1 + (i + FEEDBACK_TAP - 1) % DEPTH_DEF]);
            end
         end
         lead_idx     = 0;
         trail_idx    = FEEDBACK_TAP;
         fill_pending = 1'b0;
      endfunction

      function void set_seed(input logic [CSR_DATA_W-1:0] word);
         seed_reg = word[VALUE_W-1:0];
      endfunction

      // one accepted request beat
      function void note_draw(input logic reseed);
         int unsigned drawn;
         if (fill_pending || reseed) rebuild_table();
         lead_idx      = next_slot(lead_idx);
         trail_idx     = next_slot(trail_idx);
         drawn         = wrap_diff(lag[lead_idx], lag[trail_idx]);
         lag[lead_idx] = drawn;
         owed_values.push_back(drawn[VALUE_W-1:0]);
      endfunction

      task report_mismatch(input string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      // one accepted response beat
      task check_value(input logic [VALUE_W-1:0] got);
         logic [VALUE_W-1:0] want;
         if (owed_values.size() == 0) begin
            report_mismatch($sformatf("random_value %0d with no draw outstanding", got));
         end else begin
            want = owed_values.pop_front();
            if (got !== want)
               report_mismatch($sformatf("draw %0d: random_value %0d, predicted %0d",
                                         checked, got, want));
            checked++;
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   srg_req_if req_chan ();
   srg_rsp_if rsp_chan ();

   draw_scoreboard sb;
   bit             steady;   // no idling on either side while set

   localparam logic [CSR_DATA_W-1:0] SEED_TOP   = 32'd999999999;
   localparam logic [CSR_DATA_W-1:0] SEED_WRAP  = 32'd1000000000;
   localparam logic [CSR_DATA_W-1:0] SEED_FULL  = 32'h3FFF_FFFF;
   localparam int                    PHASES     = 6;
   localparam int                    PHASE_BEATS = 225;

   subtractive_random_generator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // generous cap on the whole run, fills included
   initial begin
      #8ms;
      $display("status: fail");
      $finish;
   end

   // response side: check each beat, then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) sb.check_value(rsp_chan.random_value);
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 14);
      end
   end

   // one request beat; valid stays high on return so back-to-back beats need no drop
   task automatic send_draw(input logic reseed);
      while (!steady && $urandom_range(0, 99) < 14) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.reseed <= reseed;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_draw(reseed);
   endtask

   // stop sending and let every owed value come back
   task automatic drain_draws();
      req_chan.valid <= 1'b0;
      while (sb.owed_values.size() != 0) @(posedge clock);
   endtask

   // setup cycle, then access cycle; only used while the block is idle
   task automatic write_seed(input logic [CSR_DATA_W-1:0] word);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({REG_SEED, 2'b00});
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_seed(word);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_seed();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 999999999);
         1:       return $urandom;                     // upper two bits are ignored
         2:       return SEED_WRAP + $urandom_range(0, 73741823);
         default: return {2'b00, 30'($urandom)};
      endcase
   endfunction

   initial begin
      sb = new();
      steady          = 1'b0;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.reseed <= 1'b0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first use with reseed set, on the reset seed: table built once
      send_draw(1'b1);
      repeat (3) send_draw(1'b0);
      drain_draws();

      // new seed must wait for the next reseed
      write_seed('0);
      repeat (2) send_draw(1'b0);
      send_draw(1'b1);
      repeat (2) send_draw(1'b0);
      drain_draws();

      // largest in-range seed, then seeds that need reducing, then seed 1
      write_seed(SEED_TOP);
      send_draw(1'b1);
      send_draw(1'b0);
      drain_draws();
      write_seed(SEED_WRAP);
      send_draw(1'b1);
      send_draw(1'b0);
      drain_draws();
      write_seed(SEED_FULL);
      send_draw(1'b1);
      send_draw(1'b0);
      drain_draws();
      write_seed(32'd1);
      send_draw(1'b1);
      send_draw(1'b0);
      drain_draws();

      // random phases: fresh seed, reseed, then long runs that wrap the indices
      for (int phase = 0; phase < PHASES; phase++) begin
         steady = (phase == 2);
         write_seed(pick_seed());
         send_draw(1'b1);
         for (int n = 1; n < PHASE_BEATS; n++) begin
            if ($urandom_range(0, 199) == 0) drain_draws();
            send_draw($urandom_range(0, 63) == 0);
         end
         drain_draws();
      end
      steady = 1'b0;

      // room for any stray beat after the last value
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.owed_values.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
